>>> hdl/rnpd_pkg.sv
// ----------------------------------------------------------------------------
// rnpd_pkg
// shared widths, limits and codes for the ring nearest point distance core
// ----------------------------------------------------------------------------
package rnpd_pkg;

    localparam int POS_W  = 30;   // ring position and ring length
    localparam int DIST_W = 29;   // circular distance
    localparam int SUM_W  = 48;   // running distance sum

    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [POS_W-1:0]  RING_LEN_RST = 30'h3FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MAX     = 29'h1FFF_FFFF;
    localparam logic [SUM_W-1:0]  SUM_MAX      = 48'hFFFF_FFFF_FFFF;

    // item kinds carried on tuser
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // packed widths of the stream payloads
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } rnpd_state_t;

endpackage

>>> hdl/ring_nearest_point_distance_core.sv
// ----------------------------------------------------------------------------
// ring_nearest_point_distance_core
// nearest stored point on a circular ring, with a saturating distance sum
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per handshake; s_tuser[0] is the kind (0 load,
//   1 query), s_tdata[29:0] the ring position
//   m_ channel: one item per query; m_tdata holds distance then total
//   cfg_wen / cfg_wdata: writes ring_length; write only while the core is idle,
//   the core itself does not enforce this
// loads and queries: a load item is written into the point memory at the
//   accepting edge; a table that is full ignores further loads
//   a query scans the stored points one memory read per cycle; no new item
//   is taken until its result is loaded into the output register, and the
//   next item is taken in the cycle after that load, so the point memory
//   read port sets the rate
//   the point at position 0 present after reset is kept as the seed of
//   every scan, so the memory needs no clearing pass after reset
// reset and stall
//   reset empties the table down to the point at 0, clears the sum and the
//   output valid and sets ring_length to its maximum
//   a stalled receiver holds the result in the output register; the next
//   item is still taken, and a following query waits at its end until the
//   output register is free
// ----------------------------------------------------------------------------
module ring_nearest_point_distance_core
    import rnpd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config register
    input  logic                 cfg_wen,
    input  logic [POS_W-1:0]     cfg_wdata,    // ring_length
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [29:0] position, [31:30] zero
    input  logic [0:0]           s_tuser,      // [0] kind
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata       // [28:0] distance, [76:29] total,
                                               // [79:77] zero
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam int PAD_W = M_TDATA_W - DIST_W - SUM_W;

    // point memory, entry 0 unused (the point at 0 is the scan seed)
    logic [POS_W-1:0] point_mem [MAX_POINTS];

    rnpd_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              lin_vld_reg, lin_vld_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [POS_W-1:0]  ring_len_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [POS_W-1:0]     q_reg;
    logic [POS_W-1:0]     rd_data_reg;
    logic [POS_W-1:0]     lin_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              s_acc;
    logic              is_query;
    logic [POS_W-1:0]  s_pos;
    logic              rd_en;
    logic              do_load;
    logic              out_load;
    logic [POS_W-1:0]  lin_c;
    logic [POS_W-1:0]  wrap_c;
    logic [POS_W-1:0]  cand_c;
    logic [DIST_W-1:0] gap_c;
    logic [SUM_W:0]    sum_add;

    assign s_pos    = s_tdata[POS_W-1:0];
    assign is_query = (s_tuser[0] == KIND_QUERY);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign do_load  = s_acc && !is_query && (count_reg < CNT_MAX);

    // one read per cycle until all stored points are issued
    assign rd_en = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);

    // linear difference of the point just read
    assign lin_c = (q_reg >= rd_data_reg) ? (q_reg - rd_data_reg)
                                          : (rd_data_reg - q_reg);

    // wrap path only when the ring is at least as long as the difference
    assign wrap_c = ring_len_reg - lin_reg;
    assign cand_c = ((ring_len_reg >= lin_reg) && (wrap_c < lin_reg)) ? wrap_c : lin_reg;
    assign gap_c  = (cand_c > {1'b0, DIST_MAX}) ? DIST_MAX : cand_c[DIST_W-1:0];

    // output register free or being emptied
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign sum_add  = {1'b0, sum_reg} + {{(SUM_W + 1 - DIST_W){1'b0}}, best_reg};

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = rd_en;
        lin_vld_next  = rd_vld_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_load) begin
                    count_next = count_reg + CNT_ONE;
                end
                if (s_acc && is_query) begin
                    rd_idx_next  = CNT_ONE;
                    lin_vld_next = 1'b1;   // seed point at 0
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_ONE;
                end
                if (!rd_en && !rd_vld_reg && !lin_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    sum_next      = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                : sum_add[SUM_W-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= CNT_ONE;
            rd_idx_reg   <= CNT_ONE;
            rd_vld_reg   <= 1'b0;
            lin_vld_reg  <= 1'b0;
            sum_reg      <= '0;
            ring_len_reg <= RING_LEN_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= rd_vld_next;
            lin_vld_reg  <= lin_vld_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                ring_len_reg <= cfg_wdata;
            end
        end
    end

    // point memory: one write port for loads, one registered read port
    always_ff @(posedge aclk) begin
        if (do_load) begin
            point_mem[count_reg[IDX_W-1:0]] <= s_pos;
        end
        if (rd_en) begin
            rd_data_reg <= point_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        if (s_acc && is_query) begin
            q_reg    <= s_pos;
            lin_reg  <= s_pos;     // distance to the point at 0
            best_reg <= DIST_MAX;
        end else begin
            if (rd_vld_reg) begin
                lin_reg <= lin_c;
            end
            if (lin_vld_reg && (gap_c < best_reg)) begin
                best_reg <= gap_c;
            end
        end
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, sum_next, best_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // table never empties and never overfills
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_ONE) && (count_reg <= CNT_MAX))
        else $error("point count out of range");

    // reads stay below the fill count and only during a scan
    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (state_reg == ST_SCAN) && (rd_idx_reg < count_reg))
        else $error("point read outside the filled table");

    // an accepted query starts a scan
    a_query_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_query) |=> (state_reg == ST_SCAN))
        else $error("query did not start a scan");

    // the running sum never decreases
    a_sum_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (sum_reg >= $past(sum_reg)))
        else $error("distance sum decreased");

    // a result appears only where a scan finished
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result without a finished scan");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ring nearest point distance core: a clocked
// driver feeds load and query items from a queue, a clocked monitor checks
// every result against a behavioral model of the point table, the ring
// length register and the saturating distance sum
// ----------------------------------------------------------------------------
module tb_top;
    import rnpd_pkg::*;

    localparam int          MAX_PTS        = 1024;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int unsigned POS_LIM        = 32'd1073741822;
    localparam int          SEG_ITEMS      = 100;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos;
    } ring_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [SUM_W-1:0]  total;
    } ring_result_t;

    // every block input is known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [POS_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    // model state: stored points, count, running sum, ring length
    logic [POS_W-1:0]     pt_pos [MAX_PTS];
    int                   pt_count;
    logic [SUM_W-1:0]     dist_total;
    logic [POS_W-1:0]     ring_len;

    ring_item_t           pending_items[$];     // items not yet offered to the core
    ring_result_t         expected_results[$];  // results owed by the core, oldest first
    logic [POS_W-1:0]     loaded_pos[$];        // every load position queued so far

    ring_item_t           next_item;
    ring_result_t         want;
    int                   send_gap;
    int                   recv_gap;
    int                   idle_cycles = 0;
    int                   error_count = 0;
    bit                   gaps_on;

    always #6 aclk = ~aclk;

    ring_nearest_point_distance_core #(
        .MAX_POINTS (MAX_PTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [29:0] position, [31:30] zero
        .s_tuser   (s_tuser),     // [0] kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)      // [28:0] distance, [76:29] total, [79:77] zero
    );

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    // circular distance from q to p; the wrap path only counts when the
    // linear gap fits inside the ring, and the answer clips at the field max
    function automatic logic [DIST_W-1:0] ring_gap(logic [POS_W-1:0] q,
                                                    logic [POS_W-1:0] p);
        logic [POS_W-1:0] lin;
        logic [POS_W-1:0] best;
        lin  = (q >= p) ? q - p : p - q;
        best = lin;
        if (ring_len >= lin && ring_len - lin < best) begin
            best = ring_len - lin;
        end
        if (best > {1'b0, DIST_MAX}) begin
            best = {1'b0, DIST_MAX};
        end
        return best[DIST_W-1:0];
    endfunction

    // apply one accepted item to the model; queries queue their result
    task automatic apply_ring_item(ring_item_t it);
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] g;
        logic [SUM_W:0]    acc;
        ring_result_t      r;
        int                i;
        if (it.kind == KIND_LOAD) begin
            // a full table drops the load
            if (pt_count < MAX_PTS) begin
                pt_pos[pt_count] = it.pos;
                pt_count++;
            end
        end else begin
            best = DIST_MAX;
            for (i = 0; i < pt_count; i++) begin
                g = ring_gap(it.pos, pt_pos[i]);
                if (g < best) begin
                    best = g;
                end
            end
            acc = {1'b0, dist_total} + {{(SUM_W + 1 - DIST_W){1'b0}}, best};
            if (acc > {1'b0, SUM_MAX}) begin
                dist_total = SUM_MAX;
            end else begin
                dist_total = acc[SUM_W-1:0];
            end
            r.distance = best;
            r.total    = dist_total;
            expected_results.push_back(r);
        end
    endtask

    task automatic log_mismatch(string what, logic [SUM_W-1:0] exp_val,
                                logic [SUM_W-1:0] act_val);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch %s: expected %0d actual %0d", what, exp_val, act_val);
        end
    endtask

    // mostly back-to-back, often short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_ring_item({s_tuser[0], s_tdata[POS_W-1:0]});
            end
            // channel free: either idle or the current item just went in
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tuser   <= next_item.kind;
                    s_tdata   <= {{(S_TDATA_W-POS_W){1'b0}}, next_item.pos};
                    send_gap  <= gaps_on ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, field-by-field compare with the oldest
    // expected result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    log_mismatch("unexpected result item", '0,
                                 SUM_W'(m_tdata[DIST_W-1:0]));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[DIST_W-1:0] !== want.distance) begin
                        log_mismatch("distance", SUM_W'(want.distance),
                                     SUM_W'(m_tdata[DIST_W-1:0]));
                    end
                    if (m_tdata[DIST_W+SUM_W-1:DIST_W] !== want.total) begin
                        log_mismatch("total", want.total,
                                     m_tdata[DIST_W+SUM_W-1:DIST_W]);
                    end
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0) begin
                    recv_gap <= pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake means the core is stuck
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ring_nearest_point_distance_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_item(logic kind, logic [POS_W-1:0] pos);
        ring_item_t it;
        it.kind = kind;
        it.pos  = pos;
        pending_items.push_back(it);
        if (kind == KIND_LOAD) begin
            loaded_pos.push_back(pos);
        end
    endtask

    // sender holds off until every owed result is back, then lets a
    // trailing load settle
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register writes only happen with the core idle
    task automatic write_ring_length(logic [POS_W-1:0] len);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        ring_len  = len;
    endtask

    // in-ring positions mostly, some near stored points for close calls,
    // some ring edges and some beyond the ring
    function automatic logic [POS_W-1:0] pick_position(logic [POS_W-1:0] len);
        int unsigned r;
        int unsigned idx;
        longint      p;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return POS_W'($urandom_range(0, POS_LIM));
        end
        if (r < 15) begin
            return ($urandom_range(0, 1) == 1) ? len - 1 : '0;
        end
        if (r < 40 && loaded_pos.size() > 0) begin
            idx = $urandom_range(0, loaded_pos.size() - 1);
            p   = longint'(loaded_pos[idx]);
            p   = p + longint'($urandom_range(0, 6)) - 3;
            if (p < 0) begin
                p = p + longint'(len);
            end
            if (p > longint'(POS_LIM)) begin
                p = longint'(POS_LIM);
            end
            return p[POS_W-1:0];
        end
        return POS_W'($urandom_range(0, len - 1));
    endfunction

    initial begin
        logic [POS_W-1:0] seg_len;
        int               seg;
        int               n;

        pt_pos[0]   = '0;
        pt_count    = 1;
        dist_total  = '0;
        ring_len    = RING_LEN_RST;
        gaps_on     = 1'b1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset ring length, lone point at 0: exact hit, wrap by one,
        // half-ring ties around the distance max
        push_item(KIND_QUERY, '0);
        push_item(KIND_QUERY, POS_W'(POS_LIM));
        push_item(KIND_QUERY, 30'h2000_0000);
        push_item(KIND_QUERY, 30'h1FFF_FFFF);
        push_item(KIND_QUERY, 30'd1);

        // smallest ring: positions beyond the ring, clipped distance,
        // wrap to zero, then loads with alternating bits and a duplicate
        write_ring_length(30'd2);
        push_item(KIND_QUERY, POS_W'(POS_LIM));
        push_item(KIND_QUERY, 30'd1);
        push_item(KIND_QUERY, 30'd2);
        push_item(KIND_QUERY, 30'd3);
        push_item(KIND_LOAD,  30'h1555_5555);
        push_item(KIND_LOAD,  30'h2AAA_AAAA);
        push_item(KIND_LOAD,  POS_W'(POS_LIM));
        push_item(KIND_LOAD,  '0);
        push_item(KIND_QUERY, 30'h2AAA_AAAB);
        push_item(KIND_QUERY, 30'h1555_5554);

        // back to the largest ring
        write_ring_length(RING_LEN_RST);
        push_item(KIND_QUERY, 30'h2000_0000);
        push_item(KIND_QUERY, 30'h1FFF_FFFF);

        // random segments, one ring length each; the middle one runs with
        // no idling on either side
        for (seg = 0; seg < 5; seg++) begin
            case (seg)
                0: seg_len = 30'd1000;
                1: seg_len = POS_W'($urandom_range(2, RING_LEN_RST));
                2: seg_len = RING_LEN_RST;
                3: seg_len = POS_W'($urandom_range(2, 64));
                default: seg_len = POS_W'($urandom_range(32'h0010_0000, 32'h2000_0000));
            endcase
            write_ring_length(seg_len);
            gaps_on = (seg != 2);
            for (n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 15) begin
                    push_item(KIND_LOAD, pick_position(seg_len));
                end else begin
                    push_item(KIND_QUERY, pick_position(seg_len));
                end
            end
        end

        // fill the table past capacity so the last loads are dropped, then
        // a few full-table queries
        write_ring_length(RING_LEN_RST);
        gaps_on = 1'b1;
        while (loaded_pos.size() < MAX_PTS + 4) begin
            push_item(KIND_LOAD, POS_W'($urandom_range(0, POS_LIM)));
        end
        push_item(KIND_QUERY, POS_W'(POS_LIM));
        push_item(KIND_QUERY, '0);
        for (n = 0; n < 14; n++) begin
            push_item(KIND_QUERY, pick_position(RING_LEN_RST));
        end

        drain();
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) begin
            log_mismatch("results still owed", SUM_W'(expected_results.size()), '0);
        end

        if (error_count == 0) begin
            $display("ring_nearest_point_distance_core verification clean");
        end else begin
            $display("ring_nearest_point_distance_core verification failed");
        end
        $finish;
    end

endmodule

>>> ring_nearest_point_distance_core.f
hdl/rnpd_pkg.sv
hdl/ring_nearest_point_distance_core.sv
test/tb_top.sv
